// ----- hw/rtl/rrmfb_pkg.sv -----
// Shared types and constants for the round-robin multi-bank FIFO bag.
package rrmfb_pkg;

  // Sizing
  localparam int NumBanks   = 4;
  localparam int BankDepth  = 16;
  localparam int ValueW     = 32;

  // Derived widths
  localparam int BankW      = (NumBanks > 1) ? $clog2(NumBanks) : 1;
  localparam int NbW        = $clog2(NumBanks + 1);
  localparam int PtrW       = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam int CntW       = $clog2(BankDepth + 1);
  localparam int AddrW      = BankW + PtrW;
  localparam int MemDepth   = NumBanks << PtrW;

  // Register and word field widths
  localparam int CfgW       = 3;
  localparam int ActiveRst  = 4;
  localparam int BankUsedW  = 2;
  localparam int InDataW    = 32;
  localparam int OutDataW   = 40;

  // Word kind on the input side
  typedef enum logic [0:0] {
    ActEnqueue = 1'b0,
    ActDequeue = 1'b1
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    FsmIdle,
    FsmReduce,
    FsmScan,
    FsmRead,
    FsmDone
  } fsm_e;

endpackage

// ----- hw/rtl/round_robin_multi_fifo_bag.sv -----
// Round-robin multi-bank FIFO bag: top level with sequencer, bank state and slot memory.
// Sequence: an enqueue passes Reduce and Done; a dequeue passes Reduce, Scan (one step per bank
//   looked at), Read and Done on a hit, or Reduce, Scan and Done when all active banks are empty.
//   Each pointer reduction after active_banks shrinks repeats Reduce. One word in flight; the next is taken
//   the cycle after the result enters the output register. The index unit steps once a cycle.
// Reset: pointers, bank head/tail/count and valid clear, active_banks returns to 4;
//   the slot memory is not cleared.
module round_robin_multi_fifo_bag (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write: active_banks
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rrmfb_pkg::CfgW-1:0]       cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rrmfb_pkg::InDataW-1:0]    s_axis_tdata,   // [31:0] value_in
  input  logic [0:0]                       s_axis_tuser,   // [0] action
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [rrmfb_pkg::OutDataW-1:0]   m_axis_tdata,   // [31:0] value_out, [33:32] bank_used
  output logic [1:0]                       m_axis_tuser    // [1:0] status
);

  localparam int NumBanks  = rrmfb_pkg::NumBanks;
  localparam int BankDepth = rrmfb_pkg::BankDepth;
  localparam int ValueW    = rrmfb_pkg::ValueW;
  localparam int BankW     = rrmfb_pkg::BankW;
  localparam int NbW       = rrmfb_pkg::NbW;
  localparam int PtrW      = rrmfb_pkg::PtrW;
  localparam int CntW      = rrmfb_pkg::CntW;
  localparam int AddrW     = rrmfb_pkg::AddrW;
  localparam int MemDepth  = rrmfb_pkg::MemDepth;
  localparam int CfgW      = rrmfb_pkg::CfgW;
  localparam int BankUsedW = rrmfb_pkg::BankUsedW;
  localparam int OutDataW  = rrmfb_pkg::OutDataW;
  localparam int PadW      = OutDataW - ValueW - BankUsedW;

  rrmfb_pkg::fsm_e state_q, state_d;

  logic [CfgW-1:0]   cfg_q;
  logic [BankW-1:0]  enq_ptr_q;
  logic [BankW-1:0]  deq_ptr_q;
  logic [PtrW-1:0]   head_q [NumBanks];
  logic [PtrW-1:0]   tail_q [NumBanks];
  logic [CntW-1:0]   cnt_q  [NumBanks];

  // per-word working registers
  rrmfb_pkg::action_e act_q;
  logic [ValueW-1:0] val_q;
  logic [NbW-1:0]    n_q;
  logic [BankW-1:0]  cur_q;
  logic [BankW-1:0]  start_q;
  logic [BankW-1:0]  steps_q;

  // result and output registers
  rrmfb_pkg::status_e res_status_q;
  logic [ValueW-1:0]  res_value_q;
  logic [BankW-1:0]   res_bank_q;
  logic               m_valid_q;
  rrmfb_pkg::status_e out_status_q;
  logic [ValueW-1:0]  out_value_q;
  logic [BankW-1:0]   out_bank_q;

  // slot memory
  logic [ValueW-1:0] mem_q [MemDepth];
  logic [ValueW-1:0] rd_data_q;

  logic [NbW-1:0]   n_used;
  logic             in_acc;
  logic             out_free;
  logic             idx_ge;
  logic [BankW-1:0] idx_sub;
  logic [BankW-1:0] idx_inc;
  logic             idx_last;
  logic             bank_hit;
  logic             bank_full;
  logic             mem_we;
  logic             mem_re;
  logic             scan_hit;
  logic             reduce_done;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == rrmfb_pkg::FsmIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // active bank count, clamped to 1..NumBanks
  always_comb begin
    if (cfg_q == '0) begin
      n_used = NbW'(1);
    end else if (32'(cfg_q) > NumBanks) begin
      n_used = NbW'(NumBanks);
    end else begin
      n_used = NbW'(cfg_q);
    end
  end

  // shared index unit: reduce, wrap-increment and last-step compare
  always_comb begin
    idx_ge   = NbW'(cur_q) >= n_q;
    idx_sub  = BankW'(NbW'(cur_q) - n_q);
    idx_inc  = ((NbW'(cur_q) + NbW'(1)) == n_q) ? '0 : BankW'(NbW'(cur_q) + NbW'(1));
    idx_last = (NbW'(steps_q) + NbW'(1)) == n_q;
  end

  assign bank_hit    = cnt_q[cur_q] != '0;
  assign bank_full   = cnt_q[cur_q] >= CntW'(BankDepth);
  assign reduce_done = (state_q == rrmfb_pkg::FsmReduce) && !idx_ge;
  assign scan_hit    = (state_q == rrmfb_pkg::FsmScan) && bank_hit;
  assign wr_addr     = {cur_q, tail_q[cur_q]};
  assign rd_addr     = {cur_q, head_q[cur_q]};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrmfb_pkg::FsmIdle: begin
        if (in_acc) state_d = rrmfb_pkg::FsmReduce;
      end
      rrmfb_pkg::FsmReduce: begin
        if (!idx_ge) begin
          state_d = (act_q == rrmfb_pkg::ActDequeue) ? rrmfb_pkg::FsmScan
                                                     : rrmfb_pkg::FsmDone;
        end
      end
      rrmfb_pkg::FsmScan: begin
        if (bank_hit) begin
          state_d = rrmfb_pkg::FsmRead;
        end else if (idx_last) begin
          state_d = rrmfb_pkg::FsmDone;
        end
      end
      rrmfb_pkg::FsmRead: begin
        state_d = rrmfb_pkg::FsmDone;
      end
      rrmfb_pkg::FsmDone: begin
        if (out_free) state_d = rrmfb_pkg::FsmIdle;
      end
      default: state_d = rrmfb_pkg::FsmIdle;
    endcase
  end

  // memory strobes
  always_comb begin
    mem_we = reduce_done && (act_q == rrmfb_pkg::ActEnqueue) && !bank_full;
    mem_re = scan_hit;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rrmfb_pkg::FsmIdle;
      cfg_q     <= CfgW'(rrmfb_pkg::ActiveRst);
      enq_ptr_q <= '0;
      deq_ptr_q <= '0;
      m_valid_q <= 1'b0;
      for (int b = 0; b < NumBanks; b++) begin
        head_q[b] <= '0;
        tail_q[b] <= '0;
        cnt_q[b]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) cfg_q <= cfg_data_i;
      // pointer advance once the start bank is reduced
      if (reduce_done) begin
        if (act_q == rrmfb_pkg::ActEnqueue) begin
          enq_ptr_q <= idx_inc;
        end else begin
          deq_ptr_q <= idx_inc;
        end
      end
      if (mem_we) begin
        tail_q[cur_q] <= (tail_q[cur_q] == PtrW'(BankDepth - 1)) ? '0
                                                                 : tail_q[cur_q] + PtrW'(1);
        cnt_q[cur_q]  <= cnt_q[cur_q] + CntW'(1);
      end
      if (mem_re) begin
        head_q[cur_q] <= (head_q[cur_q] == PtrW'(BankDepth - 1)) ? '0
                                                                 : head_q[cur_q] + PtrW'(1);
        cnt_q[cur_q]  <= cnt_q[cur_q] - CntW'(1);
      end
      if ((state_q == rrmfb_pkg::FsmDone) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q   <= rrmfb_pkg::action_e'(s_axis_tuser[0]);
      val_q   <= s_axis_tdata[ValueW-1:0];
      n_q     <= n_used;
      cur_q   <= (s_axis_tuser[0] == rrmfb_pkg::ActDequeue) ? deq_ptr_q : enq_ptr_q;
      steps_q <= '0;
    end
    unique case (state_q)
      rrmfb_pkg::FsmReduce: begin
        if (idx_ge) begin
          cur_q <= idx_sub;
        end else begin
          start_q     <= cur_q;
          res_bank_q  <= cur_q;
          res_value_q <= '0;
          res_status_q <= bank_full ? rrmfb_pkg::StFull : rrmfb_pkg::StOk;
        end
      end
      rrmfb_pkg::FsmScan: begin
        if (bank_hit) begin
          res_bank_q   <= cur_q;
          res_status_q <= rrmfb_pkg::StOk;
        end else if (idx_last) begin
          res_bank_q   <= start_q;
          res_status_q <= rrmfb_pkg::StEmpty;
          res_value_q  <= '0;
        end else begin
          cur_q   <= idx_inc;
          steps_q <= steps_q + BankW'(1);
        end
      end
      rrmfb_pkg::FsmRead: begin
        res_value_q <= rd_data_q;
      end
      default: begin
      end
    endcase
    if ((state_q == rrmfb_pkg::FsmDone) && out_free) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_bank_q   <= res_bank_q;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_addr] <= val_q;
    if (mem_re) rd_data_q <= mem_q[rd_addr];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, BankUsedW'(out_bank_q), out_value_q};

`ifndef ASSERT_OFF
  // one word at a time: ready drops right after an accept
  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input accepted while a word is in flight");

  // a write never lands in a full bank
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (cnt_q[cur_q] < CntW'(BankDepth)))
    else $error("slot write into a full bank");

  // scan stays within the active banks
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rrmfb_pkg::FsmScan) |-> ((NbW'(steps_q) < n_q) && (NbW'(cur_q) < n_q)))
    else $error("scan ran past the active banks");

  // a finished result waits while the output register is held
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == rrmfb_pkg::FsmDone) && m_valid_q && !m_axis_tready)
      |=> (state_q == rrmfb_pkg::FsmDone))
    else $error("result left the sequencer while output was stalled");
`endif

endmodule

// ----- test/testbench.sv -----
// Testbench for the round-robin multi-bank FIFO bag: bank predictor, stream drivers and checks.
`timescale 1ns / 1ps

import rrmfb_pkg::*;

// One expected output word
typedef struct packed {
  status_e               status;
  logic [ValueW-1:0]     value;
  logic [BankUsedW-1:0]  bank;
} bag_result_t;

// Bank predictor plus the queue of outstanding results
class bag_scoreboard;
  logic [CfgW-1:0]   banks_reg;
  int unsigned       enq_ptr;
  int unsigned       deq_ptr;
  logic [ValueW-1:0] slots [NumBanks][BankDepth];
  int unsigned       head [NumBanks];
  int unsigned       tail [NumBanks];
  int unsigned       fill [NumBanks];
  bag_result_t       due_q [$];
  int                errors;

  function new();
    banks_reg = CfgW'(ActiveRst);
    enq_ptr   = 0;
    deq_ptr   = 0;
    errors    = 0;
    for (int b = 0; b < NumBanks; b++) begin
      head[b] = 0;
      tail[b] = 0;
      fill[b] = 0;
    end
  endfunction

  function void set_banks(logic [CfgW-1:0] val);
    banks_reg = val;
  endfunction

  // zero acts as one bank, anything above the bank count saturates
  function int unsigned bank_span();
    if (banks_reg == 0) return 1;
    if (banks_reg > NumBanks) return NumBanks;
    return banks_reg;
  endfunction

  function int outstanding();
    return due_q.size();
  endfunction

  // Work out the result of one accepted input word
  function void note_word(action_e act, logic [ValueW-1:0] val);
    int unsigned n;
    int unsigned b;
    int unsigned start;
    bag_result_t res;
    n = bank_span();
    res.value = '0;
    if (act == ActEnqueue) begin
      b = enq_ptr % n;
      enq_ptr = (b + 1) % n;
      res.bank = BankUsedW'(b);
      if (fill[b] >= BankDepth) begin
        res.status = StFull;
      end else begin
        slots[b][tail[b]] = val;
        tail[b] = (tail[b] + 1) % BankDepth;
        fill[b]++;
        res.status = StOk;
      end
    end else begin
      start = deq_ptr % n;
      deq_ptr = (start + 1) % n;
      res.status = StEmpty;
      res.bank = BankUsedW'(start);
      // rotating scan from the start bank, first nonempty bank wins
      for (int unsigned i = 0; i < n; i++) begin
        b = (start + i) % n;
        if (res.status == StEmpty && fill[b] != 0) begin
          res.status = StOk;
          res.value = slots[b][head[b]];
          res.bank = BankUsedW'(b);
          head[b] = (head[b] + 1) % BankDepth;
          fill[b]--;
        end
      end
    end
    due_q.push_back(res);
  endfunction

  task report_mismatch(string msg);
    if (errors < 40) $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Compare one accepted output word with the oldest expectation
  task check_result(logic [OutDataW-1:0] data, logic [1:0] user);
    bag_result_t want;
    if (due_q.size() == 0) begin
      report_mismatch("output word with nothing expected");
      return;
    end
    want = due_q.pop_front();
    if (user !== want.status)
      report_mismatch($sformatf("status got %0d want %s", user, want.status.name()));
    if (data[ValueW-1:0] !== want.value)
      report_mismatch($sformatf("value_out got %h want %h", data[ValueW-1:0], want.value));
    if (data[ValueW+:BankUsedW] !== want.bank)
      report_mismatch($sformatf("bank_used got %0d want %0d", data[ValueW+:BankUsedW],
                                want.bank));
  endtask
endclass

module testbench;
  localparam int QuietLimit = 4000;
  localparam int Segments   = 15;
  localparam int SegWords   = 130;
  localparam int HoldCycles = 300;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgW-1:0]      cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;   // [31:0] value_in
  logic [0:0]           s_axis_tuser;   // [0] action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;   // [31:0] value_out, [33:32] bank_used
  logic [1:0]           m_axis_tuser;   // [1:0] status

  bag_scoreboard sb = new();

  int send_idle_pct = 9;
  int recv_idle_pct = 84;
  int hold_left     = 0;

  round_robin_multi_fifo_bag dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: random stalls, or a long hold-off when requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Watchdog: too long without any handshake
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // Offer one word, with random idle cycles ahead of it
  task automatic send_word(action_e act, logic [ValueW-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(act, val);
  endtask

  // Hold the input until every result is back, then let the block settle
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_banks(logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_banks(val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Main stimulus
  initial begin
    int      enq_pct;
    action_e act;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ActEnqueue;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: empty bag, extreme values across all four banks, drain to empty
    send_word(ActDequeue, 32'h1234_5678);
    send_word(ActEnqueue, 32'h0000_0000);
    send_word(ActEnqueue, 32'hFFFF_FFFF);
    send_word(ActEnqueue, 32'h5555_5555);
    send_word(ActEnqueue, 32'hAAAA_AAAA);
    repeat (3) send_word(ActDequeue, 32'hFFFF_FFFF);
    send_word(ActEnqueue, 32'h8000_0001);
    repeat (3) send_word(ActDequeue, 32'h0000_0000);

    // zero banks acts as one; pointers left past the new count get reduced
    drain_results();
    write_banks(3'd0);
    send_word(ActEnqueue, 32'hDEAD_BEEF);
    send_word(ActEnqueue, 32'h0000_0001);
    send_word(ActDequeue, 32'h0);

    // above the bank count saturates; earlier bank 0 entry still there
    drain_results();
    write_banks(3'd7);
    repeat (3) send_word(ActDequeue, 32'h0);

    // random segments, each with its own bank count and enqueue mix
    for (int seg = 0; seg < Segments; seg++) begin
      if (seg == 5) begin
        send_idle_pct = 84;
        recv_idle_pct = 9;
      end
      if (seg == 10) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_results();
      write_banks(CfgW'((seg * 5 + 1) % 8));
      if (seg == 2 || seg == 12) hold_left = HoldCycles;
      case (seg % 5)
        0: enq_pct = 80;
        1: enq_pct = 50;
        2: enq_pct = 30;
        3: enq_pct = 65;
        default: enq_pct = 50;
      endcase
      repeat (SegWords) begin
        act = ($urandom_range(99) < enq_pct) ? ActEnqueue : ActDequeue;
        send_word(act, pick_value());
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
